FILE: sv/dmac_pkg.sv
// Shared types and codes for the DMA controller register block.
package dmac_pkg;

  typedef enum logic [1:0] {
    CMD_READ,
    CMD_WRITE,
    CMD_DMA,
    CMD_TICK
  } cmd_t;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_UNSUP    = 3'd1;
  localparam logic [2:0] ERR_BAD_CMD  = 3'd2;
  localparam logic [2:0] ERR_DISABLED = 3'd3;
  localparam logic [2:0] ERR_MASKED   = 3'd4;
  localparam logic [2:0] ERR_MODE     = 3'd5;

  typedef struct packed {
    logic [7:0] dma_data;
    logic [1:0] channel;
    logic [7:0] write_data;
    logic [4:0] offset;
    logic       page_access;
    cmd_t       cmd;
  } item_t;

  typedef struct packed {
    logic [2:0]  error_code;
    logic        terminal_count;
    logic [7:0]  mem_data;
    logic [23:0] mem_address;
    logic        mem_write;
    logic [7:0]  read_data;
  } result_t;

endpackage

FILE: sv/dmac_regs.sv
// Channel register file, bus decode and DMA step logic.
module dmac_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             word_mode,
  input  logic             accept,
  input  dmac_pkg::item_t  item,
  output dmac_pkg::result_t result
);
  import dmac_pkg::*;

  localparam logic [3:0] REG_STATUS_CMD = 4'd8;
  localparam logic [3:0] REG_MASK       = 4'd10;
  localparam logic [3:0] REG_MODE       = 4'd11;
  localparam logic [3:0] REG_CLR_TOGGLE = 4'd12;
  localparam logic [3:0] REG_MASTER_CLR = 4'd13;
  localparam logic [7:0] MODE_TICK      = 8'h58;
  localparam logic [7:0] MODE_SINGLE_WR = 8'h44;
  localparam logic [7:0] MODE_AUTO_MASK = 8'hEF;

  logic [15:0] base_address [4];
  logic [15:0] current_address [4];
  logic [15:0] base_count [4];
  logic [15:0] current_count [4];
  logic [7:0]  channel_page [4];
  logic [7:0]  channel_mode [4];
  logic [7:0]  spare_page [4];
  logic        high_byte_toggle;
  logic [3:0]  channel_mask;
  logic        controller_enabled;

  logic [15:0] base_address_next [4];
  logic [15:0] current_address_next [4];
  logic [15:0] base_count_next [4];
  logic [15:0] current_count_next [4];
  logic [7:0]  channel_page_next [4];
  logic [7:0]  channel_mode_next [4];
  logic [7:0]  spare_page_next [4];
  logic        high_byte_toggle_next;
  logic [3:0]  channel_mask_next;
  logic        controller_enabled_next;

  logic [4:0]  num;
  logic        slot_is_ch;
  logic [1:0]  slot_idx;
  logic [1:0]  idx;
  logic [15:0] cur_a;
  logic [15:0] cur_c;
  logic [15:0] base_a;
  logic [15:0] base_c;
  logic [15:0] rd_word;
  logic [15:0] wr_word;
  logic [7:0]  mode_sel;
  logic        do_action;

  always_comb begin
    case (item.offset[2:0])
      3'd0:    begin slot_is_ch = 1'b0; slot_idx = 2'd0; end
      3'd1:    begin slot_is_ch = 1'b1; slot_idx = 2'd2; end
      3'd2:    begin slot_is_ch = 1'b1; slot_idx = 2'd3; end
      3'd3:    begin slot_is_ch = 1'b1; slot_idx = 2'd1; end
      3'd4:    begin slot_is_ch = 1'b0; slot_idx = 2'd1; end
      3'd5:    begin slot_is_ch = 1'b0; slot_idx = 2'd2; end
      3'd6:    begin slot_is_ch = 1'b0; slot_idx = 2'd3; end
      default: begin slot_is_ch = 1'b1; slot_idx = 2'd0; end
    endcase
  end

  always_comb begin
    num = word_mode ? {1'b0, item.offset[4:1]} : item.offset;
    if (item.cmd == CMD_DMA) begin
      idx = item.channel;
    end else if (item.page_access) begin
      idx = slot_idx;
    end else begin
      idx = num[2:1];
    end
    cur_a    = current_address[idx];
    cur_c    = current_count[idx];
    base_a   = base_address[idx];
    base_c   = base_count[idx];
    mode_sel = channel_mode[idx];
    rd_word  = num[0] ? cur_c : cur_a;
    wr_word  = num[0] ? base_c : base_a;
  end

  always_comb begin
    base_address_next       = base_address;
    current_address_next    = current_address;
    base_count_next         = base_count;
    current_count_next      = current_count;
    channel_page_next       = channel_page;
    channel_mode_next       = channel_mode;
    spare_page_next         = spare_page;
    high_byte_toggle_next   = high_byte_toggle;
    channel_mask_next       = channel_mask;
    controller_enabled_next = controller_enabled;
    result                  = '0;
    do_action               = 1'b0;

    case (item.cmd)
      CMD_READ: begin
        if (item.page_access) begin
          result.read_data = slot_is_ch ? channel_page[idx] : spare_page[idx];
        end else if (word_mode && item.offset[0]) begin
          result.error_code = ERR_UNSUP;
        end else if (num < 5'd8) begin
          result.read_data      = high_byte_toggle ? rd_word[15:8] : rd_word[7:0];
          high_byte_toggle_next = ~high_byte_toggle;
        end else if (num == {1'b0, REG_STATUS_CMD}) begin
          result.read_data = 8'd1;
        end else begin
          result.error_code = ERR_UNSUP;
        end
      end
      CMD_WRITE: begin
        if (item.page_access) begin
          if (slot_is_ch) begin
            channel_page_next[idx] = item.write_data;
          end else begin
            spare_page_next[idx] = item.write_data;
          end
        end else if (word_mode) begin
          if (!item.offset[0] && num >= 5'd8) begin
            do_action = 1'b1;
          end else begin
            result.error_code = ERR_UNSUP;
          end
        end else if (num < 5'd8) begin
          if (num[0]) begin
            base_count_next[idx] = high_byte_toggle ? {item.write_data, wr_word[7:0]}
                                                    : {wr_word[15:8], item.write_data};
            current_count_next[idx] = base_count_next[idx];
          end else begin
            base_address_next[idx] = high_byte_toggle ? {item.write_data, wr_word[7:0]}
                                                      : {wr_word[15:8], item.write_data};
            current_address_next[idx] = base_address_next[idx];
          end
          high_byte_toggle_next = ~high_byte_toggle;
        end else if (num[4]) begin
          result.error_code = ERR_UNSUP;
        end else begin
          do_action = 1'b1;
        end

        if (do_action) begin
          case (num[3:0])
            REG_STATUS_CMD: begin
              if ((item.write_data & 8'hFB) != 8'd0) begin
                result.error_code = ERR_BAD_CMD;
              end else begin
                controller_enabled_next = ~item.write_data[2];
              end
            end
            REG_MASK: begin
              channel_mask_next[item.write_data[1:0]] = item.write_data[2];
            end
            REG_MODE: begin
              channel_mode_next[item.write_data[1:0]] = {item.write_data[7:2], 2'b00};
            end
            REG_CLR_TOGGLE: begin
              high_byte_toggle_next = 1'b0;
            end
            REG_MASTER_CLR: begin
              for (int i = 0; i < 4; i++) begin
                base_address_next[i]    = '0;
                current_address_next[i] = '0;
                base_count_next[i]      = '0;
                current_count_next[i]   = '0;
                channel_page_next[i]    = '0;
                channel_mode_next[i]    = '0;
                spare_page_next[i]      = '0;
              end
              high_byte_toggle_next   = 1'b0;
              channel_mask_next       = '1;
              controller_enabled_next = 1'b1;
            end
            default: begin
              result.error_code = ERR_UNSUP;
            end
          endcase
        end
      end
      CMD_DMA: begin
        if (!controller_enabled) begin
          result.error_code = ERR_DISABLED;
        end else if (channel_mask[idx]) begin
          result.error_code = ERR_MASKED;
        end else if ((mode_sel & MODE_AUTO_MASK) != MODE_SINGLE_WR) begin
          result.error_code = ERR_MODE;
        end else begin
          result.mem_write        = 1'b1;
          result.mem_data         = item.dma_data;
          result.mem_address      = {channel_page[idx], cur_a};
          current_address_next[idx] = cur_a + 16'd1;
          current_count_next[idx]   = cur_c - 16'd1;
          if (cur_c == 16'd0) begin
            result.terminal_count = 1'b1;
            if (mode_sel[4]) begin
              current_address_next[idx] = base_a;
              current_count_next[idx]   = base_c;
            end else begin
              channel_mask_next[idx] = 1'b1;
            end
          end
        end
      end
      default: begin
        if (controller_enabled && channel_mode[0] == MODE_TICK) begin
          current_address_next[0] = current_address[0] - 16'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        base_address[i]    <= '0;
        current_address[i] <= '0;
        base_count[i]      <= '0;
        current_count[i]   <= '0;
        channel_page[i]    <= '0;
        channel_mode[i]    <= '0;
        spare_page[i]      <= '0;
      end
      high_byte_toggle   <= 1'b0;
      channel_mask       <= '1;
      controller_enabled <= 1'b1;
    end else if (accept) begin
      base_address       <= base_address_next;
      current_address    <= current_address_next;
      base_count         <= base_count_next;
      current_count      <= current_count_next;
      channel_page       <= channel_page_next;
      channel_mode       <= channel_mode_next;
      spare_page         <= spare_page_next;
      high_byte_toggle   <= high_byte_toggle_next;
      channel_mask       <= channel_mask_next;
      controller_enabled <= controller_enabled_next;
    end
  end

endmodule

FILE: sv/dma_controller_registers.sv
// Four-channel DMA controller register block: stream handshake and result register.
// The result item is registered and is valid in the cycle after its input item is accepted.
// Throughput: one item per cycle while m_tready is high; the single result register refills in the cycle it drains.
// Reset: synchronous rst clears all channel state, mask to all ones, enable to one,
// word_mode to zero and empties the result register.
module dma_controller_registers (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,     // word_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,      // offset, write_data, channel, dma_data, zero fill
  input  logic [2:0]  s_tuser,      // cmd, page_access
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata       // read_data, mem_write, mem_address, mem_data,
                                    // terminal_count, error_code, zero fill
);
  import dmac_pkg::*;

  logic    word_mode;
  logic    accept;
  item_t   item;
  result_t result;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  assign item.cmd         = cmd_t'(s_tuser[1:0]);
  assign item.page_access = s_tuser[2];
  assign item.offset      = s_tdata[4:0];
  assign item.write_data  = s_tdata[12:5];
  assign item.channel     = s_tdata[14:13];
  assign item.dma_data    = s_tdata[22:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      word_mode <= 1'b0;
    end else if (cfg_valid) begin
      word_mode <= cfg_data;
    end
  end

  dmac_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .word_mode (word_mode),
    .accept    (accept),
    .item      (item),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {3'b000, result};
    end
  end

endmodule
